/* hdl/cylindrical_coordinate_converter_defines.svh */
// assertion macros for the cylindrical coordinate converter
`ifndef CYLINDRICAL_COORDINATE_CONVERTER_DEFINES_SVH
`define CYLINDRICAL_COORDINATE_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS

`define CCC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

`define CCC_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define CCC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)

`define CCC_ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

/* hdl/cyl_pkg.sv */
// shared types, constants and rom functions of the cylindrical converter
package cyl_pkg;

  localparam int unsigned LANE_W             = 64;
  localparam int unsigned COORD_WIDTH_DEF    = 32;
  localparam int unsigned ROTATION_STEPS_DEF = 30;
  localparam int unsigned SCALE_LAT          = 5;

  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
  localparam logic [31:0] INV_GAIN_Q32   = 32'h9B74_EDA8;

  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic [LANE_W-1:0]        ang;
  } lane_t;

  typedef struct packed {
    logic vld;
    logic inv;
    logic axis;
  } ctrl_t;

  // shift-subtract quotient, evaluated at elaboration only
  function automatic logic [63:0] udiv_const(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // arctangent of 2^-step as a 64-bit binary angle
  function automatic logic [63:0] atan_entry(int unsigned step);
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [127:0] prod;
    int unsigned  e;
    acc = '0;
    if (step == 0) begin
      return 64'd1 << 61;
    end
    for (int unsigned k = 0; k < 32; k++) begin
      e = step * (2 * k + 1);
      if (e < 64) begin
        term = udiv_const(64'd1 << (64 - e), 64'(2 * k + 1));
        if (k[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    prod = 128'(acc) * 128'(INV_TWO_PI_Q64);
    return prod[127:64];
  endfunction

endpackage

/* hdl/cyl_rot_stage.sv */
// one registered cordic micro-rotation
module cyl_rot_stage import cyl_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  input  lane_t lane_i,
  output ctrl_t ctrl_o,
  output lane_t lane_o
);

  localparam logic [LANE_W-1:0] ATAN = atan_entry(STEP);

  logic                     cw;
  logic signed [LANE_W-1:0] dx;
  logic signed [LANE_W-1:0] dy;
  lane_t                    lane_d;
  lane_t                    lane_q;
  ctrl_t                    ctrl_q;

  // vectoring drives y to zero, rotation drives the angle to zero
  assign cw = ctrl_i.inv ? lane_i.ang[LANE_W-1] : ~lane_i.y[LANE_W-1];
  assign dx = $signed(lane_i.y) >>> STEP;
  assign dy = $signed(lane_i.x) >>> STEP;

  always_comb begin
    if (cw) begin
      lane_d.x   = lane_i.x + dx;
      lane_d.y   = lane_i.y - dy;
      lane_d.ang = lane_i.ang + ATAN;
    end else begin
      lane_d.x   = lane_i.x - dx;
      lane_d.y   = lane_i.y + dy;
      lane_d.ang = lane_i.ang - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign ctrl_o = ctrl_q;
  assign lane_o = lane_q;

endmodule

/* hdl/cyl_scale.sv */
// gain removal, rounding to whole metres and clamping of one lane
module cyl_scale import cyl_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic signed [LANE_W-1:0]      v_i,
  output logic signed [COORD_WIDTH-1:0] m_o,
  output logic                          sat_o
);

  localparam int unsigned       GUARD = LANE_W - 4 - COORD_WIDTH;
  localparam logic [LANE_W-1:0] HALF  = LANE_W'(1) << (GUARD - 1);
  localparam logic [COORD_WIDTH-1:0] MAX_M = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MIN_M = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic                     neg1_q, neg2_q, neg3_q;
  logic [LANE_W-1:0]        u1_q;
  logic [63:0]              hi2_d, hi2_q;
  logic [63:0]              lo_prod;
  logic [31:0]              lo2_q;
  logic [LANE_W-1:0]        r3_q;
  logic [LANE_W-1:0]        s4_q;
  logic [LANE_W-1:0]        t5;
  logic signed [LANE_W-1:0] m5;
  logic                     ovf5;
  logic [COORD_WIDTH-1:0]   m_q;
  logic                     sat_q;

  // two 32x32 partial products of magnitude times 1/K
  assign hi2_d   = 64'(u1_q[63:32]) * 64'(INV_GAIN_Q32);
  assign lo_prod = 64'(u1_q[31:0]) * 64'(INV_GAIN_Q32);

  // round half up, floor shift, then check the high bits for overflow
  assign t5   = s4_q + HALF;
  assign m5   = $signed(t5) >>> GUARD;
  assign ovf5 = ~((&m5[LANE_W-1:COORD_WIDTH-1]) | ~(|m5[LANE_W-1:COORD_WIDTH-1]));

  always_ff @(posedge clk_i) begin
    neg1_q <= v_i[LANE_W-1];
    u1_q   <= v_i[LANE_W-1] ? LANE_W'(-v_i) : LANE_W'(v_i);
    neg2_q <= neg1_q;
    hi2_q  <= hi2_d;
    lo2_q  <= lo_prod[63:32];
    neg3_q <= neg2_q;
    r3_q   <= hi2_q + {32'd0, lo2_q};
    s4_q   <= neg3_q ? LANE_W'(-r3_q) : r3_q;
    sat_q  <= ovf5;
    if (ovf5) begin
      m_q <= m5[LANE_W-1] ? MIN_M : MAX_M;
    end else begin
      m_q <= m5[COORD_WIDTH-1:0];
    end
  end

  assign m_o   = $signed(m_q);
  assign sat_o = sat_q;

endmodule

/* hdl/cylindrical_coordinate_converter.sv */
// top level of the pipelined cartesian / cylindrical converter
//
// usage
// - one command channel: a word is taken at a rising edge with start high and
//   busy low; busy is tied low, so a new word can enter every cycle
// - func_i 0 turns x, y, z into radius, azimuth, height; func_i 1 turns
//   radius, azimuth, height into x, y, z; coord_c_i passes straight through
// - each result word shows on the out ports for one cycle with done_o high
// - throughput is one word per cycle: one prerotation register, one register
//   per cordic step, a five stage gain and rounding unit and an output register
// - the receiver cannot stall, so nothing is held back; the pipe never stops
// - reset clears only the control and valid bits; words in flight are dropped
// - on_axis_o marks a forward word with x and y both zero (azimuth forced 0)
// - saturated_o marks a radius, x or y clamped to the signed field range
// - azimuth is a binary angle with 2^COORD_WIDTH per turn, pi read as the
//   most negative value
`include "cylindrical_coordinate_converter_defines.svh"

module cylindrical_coordinate_converter import cyl_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int unsigned ROTATION_STEPS = ROTATION_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func_i,
  input  logic signed [COORD_WIDTH-1:0] coord_a_i,
  input  logic signed [COORD_WIDTH-1:0] coord_b_i,
  input  logic signed [COORD_WIDTH-1:0] coord_c_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] out_a_o,
  output logic signed [COORD_WIDTH-1:0] out_b_o,
  output logic signed [COORD_WIDTH-1:0] out_c_o,
  output logic                          on_axis_o,
  output logic                          saturated_o
);

  // fraction bits carried in the 64-bit lanes
  localparam int unsigned GUARD     = LANE_W - 4 - COORD_WIDTH;
  localparam int unsigned PAD_W     = LANE_W - COORD_WIDTH;
  // height delay line length, up to the output register
  localparam int unsigned CDLY      = ROTATION_STEPS + SCALE_LAT + 1;
  // registers between the accept edge and the strobe
  localparam int unsigned PIPE_REGS = ROTATION_STEPS + SCALE_LAT + 2;
  localparam logic [LANE_W-1:0] ANG_HALF = LANE_W'(1) << (LANE_W - 1 - COORD_WIDTH);

  logic                     accept;
  logic signed [LANE_W-1:0] a_sh;
  logic signed [LANE_W-1:0] b_sh;
  logic [LANE_W-1:0]        ang_in;
  logic                     fwd_flip;
  logic                     inv_flip;
  lane_t                    lane0_d;
  ctrl_t                    ctrl0_d;

  lane_t lane [ROTATION_STEPS+1];
  ctrl_t ctrl [ROTATION_STEPS+1];

  logic [COORD_WIDTH-1:0] c_dly_q [CDLY];

  logic [LANE_W-1:0]      ang_rnd;
  ctrl_t                  side_q     [SCALE_LAT];
  logic [COORD_WIDTH-1:0] side_ang_q [SCALE_LAT];

  logic signed [COORD_WIDTH-1:0] sx_m;
  logic signed [COORD_WIDTH-1:0] sy_m;
  logic                          sx_sat;
  logic                          sy_sat;

  ctrl_t                  tail;
  logic                   done_q;
  logic [COORD_WIDTH-1:0] out_a_q, out_b_q, out_c_q;
  logic                   on_axis_q, sat_q;

  // the pipe always advances
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------------
  // prerotation: bring the vector or the angle into the right half plane
  // ---------------------------------------------------------------------
  assign a_sh   = {{PAD_W{coord_a_i[COORD_WIDTH-1]}}, coord_a_i} <<< GUARD;
  assign b_sh   = {{PAD_W{coord_b_i[COORD_WIDTH-1]}}, coord_b_i} <<< GUARD;
  assign ang_in = {coord_b_i, {PAD_W{1'b0}}};

  // forward: left half plane rotates by pi
  assign fwd_flip = coord_a_i[COORD_WIDTH-1];
  // inverse: angle beyond a quarter turn rotates by pi, which negates r
  assign inv_flip = ang_in[LANE_W-1] ^ ang_in[LANE_W-2];

  always_comb begin
    ctrl0_d.vld  = accept;
    ctrl0_d.inv  = func_i;
    ctrl0_d.axis = ~func_i & (coord_a_i == '0) & (coord_b_i == '0);
    if (func_i) begin
      lane0_d.x   = inv_flip ? LANE_W'(-a_sh) : a_sh;
      lane0_d.y   = '0;
      lane0_d.ang = {ang_in[LANE_W-1] ^ inv_flip, ang_in[LANE_W-2:0]};
    end else begin
      lane0_d.x   = fwd_flip ? LANE_W'(-a_sh) : a_sh;
      lane0_d.y   = fwd_flip ? LANE_W'(-b_sh) : b_sh;
      lane0_d.ang = {fwd_flip, {(LANE_W-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl[0] <= '0;
    end else begin
      ctrl[0] <= ctrl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lane[0] <= lane0_d;
  end

  // ---------------------------------------------------------------------
  // cordic chain, one micro-rotation per register stage
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_rot
    cyl_rot_stage #(
      .STEP (i)
    ) u_rot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[i]),
      .lane_i (lane[i]),
      .ctrl_o (ctrl[i+1]),
      .lane_o (lane[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // gain removal and rounding, both lanes
  // ---------------------------------------------------------------------
  cyl_scale #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_scale_x (
    .clk_i (clk_i),
    .v_i   (lane[ROTATION_STEPS].x),
    .m_o   (sx_m),
    .sat_o (sx_sat)
  );

  cyl_scale #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_scale_y (
    .clk_i (clk_i),
    .v_i   (lane[ROTATION_STEPS].y),
    .m_o   (sy_m),
    .sat_o (sy_sat)
  );

  // azimuth rounded half up to the field width, travels beside the scaler
  assign ang_rnd = lane[ROTATION_STEPS].ang + ANG_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SCALE_LAT; k++) begin
        side_q[k] <= '0;
      end
    end else begin
      side_q[0] <= ctrl[ROTATION_STEPS];
      for (int k = 1; k < SCALE_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_ang_q[0] <= ang_rnd[LANE_W-1 -: COORD_WIDTH];
    for (int k = 1; k < SCALE_LAT; k++) begin
      side_ang_q[k] <= side_ang_q[k-1];
    end
  end

  // height passes through a plain delay line
  always_ff @(posedge clk_i) begin
    c_dly_q[0] <= coord_c_i;
    for (int k = 1; k < CDLY; k++) begin
      c_dly_q[k] <= c_dly_q[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // output register: pick radius/azimuth or x/y, apply the on-axis case
  // ---------------------------------------------------------------------
  assign tail = side_q[SCALE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tail.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_c_q   <= c_dly_q[CDLY-1];
    on_axis_q <= tail.axis & ~tail.inv;
    if (tail.inv) begin
      out_a_q <= sx_m;
      out_b_q <= sy_m;
      sat_q   <= sx_sat | sy_sat;
    end else if (tail.axis) begin
      out_a_q <= '0;
      out_b_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      out_a_q <= sx_m;
      out_b_q <= side_ang_q[SCALE_LAT-1];
      sat_q   <= sx_sat;
    end
  end

  assign done_o      = done_q;
  assign out_a_o     = $signed(out_a_q);
  assign out_b_o     = $signed(out_b_q);
  assign out_c_o     = $signed(out_c_q);
  assign on_axis_o   = on_axis_q;
  assign saturated_o = sat_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // every strobe belongs to an accepted word that went through all PIPE_REGS registers
  `CCC_ASSERT_IMPLIES(a_fixed_latency, clk_i, rst_ni, done_o, $past(accept, PIPE_REGS))

  // on-axis words give zero radius and azimuth and never saturate
  `CCC_ASSERT_IMPLIES(a_axis_zero, clk_i, rst_ni, done_o && on_axis_o, out_a_o == '0 && out_b_o == '0 && !saturated_o)

  // vectoring leaves x nonnegative at the end of the chain
  `CCC_ASSERT_NEVER(a_fwd_x_sign, clk_i, rst_ni, ctrl[ROTATION_STEPS].vld && !ctrl[ROTATION_STEPS].inv && lane[ROTATION_STEPS].x[LANE_W-1])

endmodule
